// ===== hdl/clkds_pkg.sv =====
package clkds_pkg;

	localparam int TGT_W       = 24;
	localparam int OSC_W       = 24;
	localparam int OPD_W       = 4;
	localparam int CPD_W       = 13;
	localparam int CNT_W       = 8;
	localparam int CI_W        = 3;
	localparam int OI_W        = 2;
	localparam int NUM_CNT     = 6;
	localparam int NUM_OSC     = 4;
	localparam int MAX_RESULTS = 24;
	localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
	localparam int N_W         = $clog2(MAX_RESULTS + 1);

	localparam int COUNT_LIMIT_DEF = 255;
	localparam int FRAC_BITS_DEF   = 8;
	localparam logic [OSC_W-1:0] OSC_RESET = OSC_W'(25000);

	localparam logic [CI_W-1:0] CI_LAST = CI_W'(NUM_CNT - 1);
	localparam logic [OI_W-1:0] OI_LAST = OI_W'(NUM_OSC - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LOAD,
		ST_RUN,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	// one divider setting, as loop indexes plus reload value
	typedef struct packed {
		logic [CI_W-1:0]  ci;
		logic [OI_W-1:0]  oi;
		logic [CNT_W-1:0] count;
	} combo_t;

	typedef struct packed {
		logic                 start;
		logic                 mul;
		logic                 load;
		logic                 step;
		combo_t               tag;
		logic                 emit;
		logic [RES_IDX_W-1:0] emit_idx;
		logic                 emit_last;
	} cmd_t;

	typedef struct packed {
		logic           out_free;
		logic           exact_seen;
		logic [N_W-1:0] n;
	} status_t;

	function automatic logic [CPD_W-1:0] cnt_prediv_f(input logic [CI_W-1:0] ci);
		logic [CPD_W-1:0] v;
		case (ci)
			3'd0: v = CPD_W'(1);
			3'd1: v = CPD_W'(4);
			3'd2: v = CPD_W'(12);
			3'd3: v = CPD_W'(24);
			3'd4: v = CPD_W'(64);
			3'd5: v = CPD_W'(4096);
			default: v = CPD_W'(1);
		endcase
		return v;
	endfunction

	function automatic logic [OPD_W-1:0] osc_prediv_f(input logic [OI_W-1:0] oi);
		return OPD_W'(1) << oi;
	endfunction

endpackage

// ===== hdl/clkds_if.sv =====
interface clkds_req_if import clkds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TGT_W-1:0] target_freq_q8;

	modport source (output valid, output target_freq_q8, input ready);
	modport sink (input valid, input target_freq_q8, output ready);
endinterface

interface clkds_res_if import clkds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OPD_W-1:0] osc_prediv;
	logic [CPD_W-1:0] cnt_prediv;
	logic [CNT_W-1:0] count_value;
	logic             is_exact;
	logic             found;
	logic             last;

	modport source (output valid, output osc_prediv, output cnt_prediv, output count_value,
		output is_exact, output found, output last, input ready);
	modport sink (input valid, input osc_prediv, input cnt_prediv, input count_value,
		input is_exact, input found, input last, output ready);
endinterface

// ===== hdl/clock_divider_setting_search_top.sv =====
// clock divider setting search
// req carries one target frequency word (unsigned, FRAC_BITS fraction bits) and
// is taken when valid and ready are both high; ready is high only while idle.
// cfg_we / cfg_wdata write the oscillator frequency (reset 25000); write only
// while idle.
// for each word the block walks counter prescalers 1,4,12,24,64,4096, then
// oscillator prescalers 1,2,4,8, then reload values 1 to COUNT_LIMIT-1, one
// candidate per cycle on an accumulated product; each prescaler pair first passes
// a multiply state and a load state; after the search the result words follow,
// one word per cycle while res does not stall.
// res gives every exact setting in search order (at most 24), or else one word
// with the nearest setting, or found low if none beats the oscillator bound;
// last marks the final word of a request.
// results leave through an output register; a stall on res holds the word and
// pauses emission, and the next request is taken once the last word is loaded.
// reset clears the controller and returns the register to its reset value.
module clock_divider_setting_search_top import clkds_pkg::*; #(
	parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	clkds_req_if.sink        req,
	clkds_res_if.source      res,
	input  logic             cfg_we,
	input  logic [OSC_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	status_t st;

	clkds_ctrl #(
		.COUNT_LIMIT(COUNT_LIMIT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	clkds_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.target    (req.target_freq_q8),
		.cmd       (cmd),
		.st        (st),
		.res       (res)
	);

endmodule

// ===== hdl/clkds_dp.sv =====
module clkds_dp import clkds_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [OSC_W-1:0]   cfg_wdata,
	input  logic [TGT_W-1:0]   target,
	input  cmd_t               cmd,
	output status_t            st,
	clkds_res_if.source        res
);

	localparam int TP_W   = TGT_W + CPD_W;
	localparam int BASE_W = TP_W + OI_W + 1;
	localparam int PW     = BASE_W + CNT_W;

	logic [OSC_W-1:0]  osc_q;
	logic [TGT_W-1:0]  target_q;
	logic [TP_W-1:0]   tprod_q;
	logic [BASE_W-1:0] base_q;
	logic [PW-1:0]     prod_q;

	logic              v_s1;
	logic              eq_s1;
	logic              far_s1;
	logic [OSC_W-1:0]  dist_s1;
	combo_t            tag_s1;

	logic [OSC_W-1:0]  best_dist_q;
	combo_t            best_q;
	logic              best_valid_q;
	logic              exact_seen_q;
	logic [N_W-1:0]    n_q;
	combo_t            list_q [MAX_RESULTS];

	logic              res_valid_q;

	logic [PW-1:0]     goal;
	logic [PW-1:0]     diff;
	logic [PW-1:0]     dist_full;
	logic [BASE_W-1:0] base_next;
	combo_t            sel;
	logic              sel_found;
	logic              sel_exact;

	assign goal      = PW'(osc_q) << FRAC_BITS;
	assign diff      = (prod_q > goal) ? (prod_q - goal) : (goal - prod_q);
	assign dist_full = diff >> FRAC_BITS;
	assign base_next = BASE_W'(tprod_q) << cmd.tag.oi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_q <= OSC_RESET;
		end else if (cfg_we) begin
			osc_q <= cfg_wdata;
		end
	end

	// product for reload value k+1 is the one for k plus the base
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			target_q <= target;
		end
		if (cmd.mul) begin
			tprod_q <= TP_W'(target_q) * TP_W'(cnt_prediv_f(cmd.tag.ci));
		end
		if (cmd.load) begin
			base_q <= base_next;
			prod_q <= PW'(base_next);
		end else if (cmd.step) begin
			prod_q <= prod_q + PW'(base_q);
		end
	end

	always_ff @(posedge clk) begin
		eq_s1   <= (prod_q == goal);
		far_s1  <= |dist_full[PW-1:OSC_W];
		dist_s1 <= dist_full[OSC_W-1:0];
		tag_s1  <= cmd.tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			exact_seen_q <= 1'b0;
			n_q          <= '0;
		end else if (cmd.start) begin
			best_valid_q <= 1'b0;
			exact_seen_q <= 1'b0;
			n_q          <= '0;
		end else if (v_s1) begin
			if (eq_s1) begin
				exact_seen_q <= 1'b1;
				if (n_q < N_W'(MAX_RESULTS)) begin
					n_q <= n_q + 1'b1;
				end
			end else if (!exact_seen_q && !far_s1 && dist_s1 < best_dist_q) begin
				best_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_dist_q <= osc_q;
			best_q      <= '0;
		end else if (v_s1) begin
			if (eq_s1) begin
				if (n_q < N_W'(MAX_RESULTS)) begin
					list_q[n_q[RES_IDX_W-1:0]] <= tag_s1;
				end
			end else if (!exact_seen_q && !far_s1 && dist_s1 < best_dist_q) begin
				best_dist_q <= dist_s1;
				best_q      <= tag_s1;
			end
		end
	end

	always_comb begin
		if (exact_seen_q) begin
			sel       = list_q[cmd.emit_idx];
			sel_found = 1'b1;
			sel_exact = 1'b1;
		end else begin
			sel       = best_q;
			sel_found = best_valid_q;
			sel_exact = 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res.osc_prediv  <= sel_found ? osc_prediv_f(sel.oi) : '0;
			res.cnt_prediv  <= sel_found ? cnt_prediv_f(sel.ci) : '0;
			res.count_value <= sel_found ? sel.count : '0;
			res.is_exact    <= sel_exact;
			res.found       <= sel_found;
			res.last        <= cmd.emit_last;
		end
	end

	assign res.valid = res_valid_q;

	assign st.out_free   = !res_valid_q || res.ready;
	assign st.exact_seen = exact_seen_q;
	assign st.n          = n_q;

	a_exact_stored: assert property (@(posedge clk) disable iff (!arst_n)
		exact_seen_q |-> (n_q != '0))
		else $error("exact match seen but none stored");

	a_best_below_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !cmd.start && !exact_seen_q && best_valid_q) |-> (best_dist_q < osc_q))
		else $error("best distance not below oscillator bound");

endmodule

// ===== hdl/clkds_ctrl.sv =====
module clkds_ctrl import clkds_pkg::*; #(
	parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  status_t      st,
	output cmd_t         cmd
);

	localparam logic [CNT_W-1:0] COUNT_END = CNT_W'(COUNT_LIMIT - 1);

	state_t               state_q;
	state_t               state_d;
	logic [CI_W-1:0]      ci_q;
	logic [OI_W-1:0]      oi_q;
	logic [CNT_W-1:0]     count_q;
	logic [RES_IDX_W-1:0] k_q;

	logic                 accept;
	logic                 run_end;
	logic                 grp_last;
	logic [RES_IDX_W-1:0] last_idx;
	logic                 emit_last;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign run_end   = (count_q == COUNT_END);
	assign grp_last  = (ci_q == CI_LAST) && (oi_q == OI_LAST);
	assign last_idx  = st.exact_seen ? RES_IDX_W'(st.n - 1'b1) : '0;
	assign emit_last = (k_q == last_idx);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (req_valid) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_RUN;
			ST_RUN: begin
				if (run_end) begin
					state_d = grp_last ? ST_FLUSH : ST_SETUP;
				end
			end
			ST_FLUSH: state_d = ST_EMIT;
			ST_EMIT: begin
				if (st.out_free && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = 1'b0;
		cmd           = '0;
		cmd.tag.ci    = ci_q;
		cmd.tag.oi    = oi_q;
		cmd.tag.count = count_q;
		cmd.emit_idx  = k_q;
		cmd.emit_last = emit_last;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.start = req_valid;
			end
			ST_SETUP: cmd.mul  = 1'b1;
			ST_LOAD:  cmd.load = 1'b1;
			ST_RUN:   cmd.step = 1'b1;
			ST_EMIT:  cmd.emit = st.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ci_q    <= '0;
			oi_q    <= '0;
			count_q <= CNT_W'(1);
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					ci_q    <= '0;
					oi_q    <= '0;
					count_q <= CNT_W'(1);
					k_q     <= '0;
				end
				ST_LOAD: count_q <= CNT_W'(1);
				ST_RUN: begin
					count_q <= count_q + 1'b1;
					if (run_end && !grp_last) begin
						if (oi_q == OI_LAST) begin
							oi_q <= '0;
							ci_q <= ci_q + 1'b1;
						end else begin
							oi_q <= oi_q + 1'b1;
						end
					end
				end
				ST_EMIT: if (st.out_free) k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	a_start_setup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SETUP && ci_q == '0 && oi_q == '0))
		else $error("search did not start at first setting");

	a_search_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && run_end && grp_last) |=> (state_q == ST_FLUSH))
		else $error("search did not end after last group");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (k_q <= last_idx))
		else $error("emit index past last result");

endmodule
